// ===== hw/rtl/thermal_frame_extremes_defines.svh =====
// assertion macros shared by the thermal frame extremes checker
// no dependencies; included by bare file name
`ifndef THERMAL_FRAME_EXTREMES_DEFINES_SVH
`define THERMAL_FRAME_EXTREMES_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TFE_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tfe checker: same-cycle implication failed");

// next-cycle implication, disabled in reset
`define TFE_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tfe checker: next-cycle implication failed");

`endif

// ===== hw/rtl/tfe_pkg.sv =====
// types and constants for the thermal frame extremes block
// no dependencies; used by every other rtl file but the defines header
package tfe_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned RAW_W       = 16;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned SCALE_W     = 10;
  localparam int unsigned PROD_W      = 26;
  localparam int unsigned REF_TEMP_W  = 21;
  localparam int unsigned BODY_TEMP_W = 20;
  localparam int unsigned MIN_TEMP_W  = 27;

  // temperature in 0.0001 degC is raw * 636 - 799000
  localparam logic [SCALE_W-1:0]    TEMP_SCALE  = 10'd636;
  localparam logic [MIN_TEMP_W-1:0] TEMP_OFFSET = 27'd799000;
  localparam logic [MIN_TEMP_W-1:0] NO_MIN_TEMP = 27'd40000000;

  // raw bounds equivalent to temperature at or above 0 degC and at or below 4000 degC
  localparam logic [RAW_W-1:0] RAW_MAX_FLOOR = 16'd1257;
  localparam logic [RAW_W-1:0] RAW_MIN_CEIL  = 16'd64149;

  localparam logic [BYTE_W-1:0] HEADER_LENGTH_RST = 8'd31;
  localparam logic [RAW_W-1:0]  REF_CEIL_RST      = 16'd3000;
  localparam logic [RAW_W-1:0]  BODY_CEIL_RST     = 16'd2500;
  localparam logic [RAW_W-1:0]  MIN_FLOOR_RST     = 16'd1000;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEADER_LENGTH = 8'd0,
    REG_REF_MAX_CEIL  = 8'd1,
    REG_BODY_MAX_CEIL = 8'd2,
    REG_MIN_FLOOR     = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] header_length;
    logic [RAW_W-1:0]  ref_max_ceiling;
    logic [RAW_W-1:0]  body_max_ceiling;
    logic [RAW_W-1:0]  min_floor;
  } cfg_regs_t;

  typedef struct packed {
    logic             has_pixel;
    logic [RAW_W-1:0] raw;
    logic             last;
  } pix_tok_t;

  typedef struct packed {
    logic [RAW_W-1:0]   ref_max_raw;
    logic [RAW_W-1:0]   body_max_raw;
    logic [RAW_W-1:0]   min_raw;
    logic               min_found;
    logic [COUNT_W-1:0] count;
  } snap_t;

  typedef struct packed {
    logic [PROD_W-1:0]  ref_prod;
    logic [PROD_W-1:0]  body_prod;
    logic [PROD_W-1:0]  min_prod;
    logic               min_found;
    logic [COUNT_W-1:0] count;
  } prod_t;

endpackage

// ===== hw/rtl/tfe_byte_if.sv =====
// frame byte channel: valid, ready and one byte with its end-of-frame mark
// depends on tfe_pkg
interface tfe_byte_if;
  import tfe_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/tfe_cfg_if.sv =====
// configuration write channel: valid, ready, register index and write data
// depends on tfe_pkg
interface tfe_cfg_if;
  import tfe_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/tfe_result_if.sv =====
// result channel: valid, ready and the per-frame extreme temperatures
// depends on tfe_pkg
interface tfe_result_if;
  import tfe_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [REF_TEMP_W-1:0]         reference_max_temp;
  logic [BODY_TEMP_W-1:0]        body_max_temp;
  logic signed [MIN_TEMP_W-1:0]  scene_min_temp;
  logic [COUNT_W-1:0]            pixel_count;

  modport source (output valid, output reference_max_temp, output body_max_temp,
                  output scene_min_temp, output pixel_count, input ready);
  modport sink (input valid, input reference_max_temp, input body_max_temp,
                input scene_min_temp, input pixel_count, output ready);
endinterface

// ===== hw/rtl/tfe_queue.sv =====
// short token queue between the byte front end and the tracking back end
// depends on tfe_pkg
module tfe_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tfe_pkg::pix_tok_t wr_data,
  output logic              full,
  input  logic              pop,
  output tfe_pkg::pix_tok_t rd_data,
  output logic              empty
);
  import tfe_pkg::*;

  pix_tok_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     fill;
  logic                do_push;
  logic                do_pop;

  assign full    = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end
endmodule

// ===== hw/rtl/tfe_front.sv =====
// front end: header skip and high/low byte pairing into raw pixel tokens
// depends on tfe_pkg and tfe_byte_if
module tfe_front (
  input  logic               clk,
  input  logic               rst,
  tfe_byte_if.sink           frame,
  input  tfe_pkg::cfg_regs_t cfg_regs,
  output tfe_pkg::pix_tok_t  tok,
  output logic               tok_push,
  input  logic               q_full
);
  import tfe_pkg::*;

  logic [BYTE_W-1:0] byte_position;
  logic              pair_phase;
  logic [BYTE_W-1:0] held_high_byte;
  logic              accept;
  logic              in_header;

  assign frame.ready = !q_full;
  assign accept      = frame.valid && frame.ready;
  assign in_header   = (byte_position < cfg_regs.header_length);

  assign tok.has_pixel = !in_header && pair_phase;
  assign tok.raw       = {held_high_byte, frame.data_byte};
  assign tok.last      = frame.last_byte;
  assign tok_push      = accept && (tok.has_pixel || frame.last_byte);

  always_ff @(posedge clk) begin
    if (accept && !in_header && !pair_phase) begin
      held_high_byte <= frame.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      pair_phase    <= 1'b0;
    end else if (accept) begin
      if (frame.last_byte) begin
        byte_position <= '0;
        pair_phase    <= 1'b0;
      end else if (in_header) begin
        byte_position <= byte_position + 1'b1;
      end else begin
        pair_phase <= !pair_phase;
      end
    end
  end
endmodule

// ===== hw/rtl/tfe_back.sv =====
// back end: gated extreme tracking, frame snapshot, scaling and result register
// depends on tfe_pkg and tfe_result_if
module tfe_back #(
  parameter int unsigned VALID_PIXELS = 4785
) (
  input  logic               clk,
  input  logic               rst,
  input  tfe_pkg::cfg_regs_t cfg_regs,
  input  tfe_pkg::pix_tok_t  tok,
  input  logic               q_empty,
  output logic               pop,
  tfe_result_if.source       result
);
  import tfe_pkg::*;

  snap_t trk;
  snap_t trk_next;
  snap_t snap;
  logic  snap_valid;
  prod_t prod;
  logic  prod_valid;

  logic out_free;
  logic prod_free;
  logic snap_free;

  logic signed [MIN_TEMP_W-1:0] ref_t;
  logic signed [MIN_TEMP_W-1:0] body_t;
  logic signed [MIN_TEMP_W-1:0] min_t;

  assign out_free  = !result.valid || result.ready;
  assign prod_free = !prod_valid || out_free;
  assign snap_free = !snap_valid || prod_free;
  assign pop       = !q_empty && (!tok.last || snap_free);

  always_comb begin
    logic counted;
    logic max_ok;
    logic min_ok;
    counted  = tok.has_pixel && (trk.count < COUNT_W'(VALID_PIXELS));
    max_ok   = counted && (tok.raw >= RAW_MAX_FLOOR);
    min_ok   = counted && (tok.raw > cfg_regs.min_floor) && (tok.raw <= RAW_MIN_CEIL);
    trk_next = trk;
    if (counted) begin
      trk_next.count = trk.count + 1'b1;
    end
    if (max_ok && (tok.raw < cfg_regs.ref_max_ceiling) && (tok.raw > trk.ref_max_raw)) begin
      trk_next.ref_max_raw = tok.raw;
    end
    if (max_ok && (tok.raw < cfg_regs.body_max_ceiling) && (tok.raw > trk.body_max_raw)) begin
      trk_next.body_max_raw = tok.raw;
    end
    if (min_ok && (!trk.min_found || (tok.raw < trk.min_raw))) begin
      trk_next.min_raw   = tok.raw;
      trk_next.min_found = 1'b1;
    end
  end

  // tracker state, cleared at each frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      trk.ref_max_raw  <= '0;
      trk.body_max_raw <= '0;
      trk.min_raw      <= '1;
      trk.min_found    <= 1'b0;
      trk.count        <= '0;
    end else if (pop) begin
      if (tok.last) begin
        trk.ref_max_raw  <= '0;
        trk.body_max_raw <= '0;
        trk.min_raw      <= '1;
        trk.min_found    <= 1'b0;
        trk.count        <= '0;
      end else begin
        trk <= trk_next;
      end
    end
  end

  // frame snapshot stage
  always_ff @(posedge clk) begin
    if (pop && tok.last) begin
      snap <= trk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (pop && tok.last) begin
      snap_valid <= 1'b1;
    end else if (prod_free) begin
      snap_valid <= 1'b0;
    end
  end

  // scaling stage
  always_ff @(posedge clk) begin
    if (prod_free && snap_valid) begin
      prod.ref_prod  <= PROD_W'(snap.ref_max_raw) * PROD_W'(TEMP_SCALE);
      prod.body_prod <= PROD_W'(snap.body_max_raw) * PROD_W'(TEMP_SCALE);
      prod.min_prod  <= PROD_W'(snap.min_raw) * PROD_W'(TEMP_SCALE);
      prod.min_found <= snap.min_found;
      prod.count     <= snap.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_free) begin
      prod_valid <= snap_valid;
    end
  end

  // offset and clamp into the output register
  assign ref_t  = MIN_TEMP_W'(prod.ref_prod) - TEMP_OFFSET;
  assign body_t = MIN_TEMP_W'(prod.body_prod) - TEMP_OFFSET;
  assign min_t  = MIN_TEMP_W'(prod.min_prod) - TEMP_OFFSET;

  always_ff @(posedge clk) begin
    if (out_free && prod_valid) begin
      if (ref_t[MIN_TEMP_W-1]) begin
        result.reference_max_temp <= '0;
      end else if (|ref_t[MIN_TEMP_W-2:REF_TEMP_W]) begin
        result.reference_max_temp <= '1;
      end else begin
        result.reference_max_temp <= ref_t[REF_TEMP_W-1:0];
      end
      if (body_t[MIN_TEMP_W-1]) begin
        result.body_max_temp <= '0;
      end else if (|body_t[MIN_TEMP_W-2:BODY_TEMP_W]) begin
        result.body_max_temp <= '1;
      end else begin
        result.body_max_temp <= body_t[BODY_TEMP_W-1:0];
      end
      result.scene_min_temp <= prod.min_found ? min_t : $signed(NO_MIN_TEMP);
      result.pixel_count    <= prod.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= prod_valid;
    end
  end
endmodule

// ===== hw/rtl/thermal_frame_extremes.sv =====
// thermal frame extremes: one byte per cycle in while the token queue is not full, one result per frame out
// result path: the last byte's token passes the token queue, then the snapshot, scaling and output registers
// throughput: one byte per cycle while the 4-entry token queue is not full, set by the front end and that queue
// a new frame may start on the cycle after a last byte; results queue behind a 3-stage pipe
// reset (synchronous, active high): registers return to defaults, trackers and queue empty
// depends on tfe_pkg, the channel interfaces, tfe_queue, tfe_front and tfe_back
module thermal_frame_extremes #(
  parameter int unsigned VALID_PIXELS = 4785
) (
  input  logic          clk,
  input  logic          rst,
  tfe_byte_if.sink      frame,
  tfe_cfg_if.sink       cfg,
  tfe_result_if.source  result
);
  import tfe_pkg::*;

  cfg_regs_t cfg_regs;
  pix_tok_t  front_tok;
  pix_tok_t  head_tok;
  logic      tok_push;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.header_length    <= HEADER_LENGTH_RST;
      cfg_regs.ref_max_ceiling  <= REF_CEIL_RST;
      cfg_regs.body_max_ceiling <= BODY_CEIL_RST;
      cfg_regs.min_floor        <= MIN_FLOOR_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_HEADER_LENGTH: cfg_regs.header_length    <= cfg.data[BYTE_W-1:0];
        REG_REF_MAX_CEIL:  cfg_regs.ref_max_ceiling  <= cfg.data;
        REG_BODY_MAX_CEIL: cfg_regs.body_max_ceiling <= cfg.data;
        REG_MIN_FLOOR:     cfg_regs.min_floor        <= cfg.data;
        default:           cfg_regs                  <= cfg_regs;
      endcase
    end
  end

  tfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .frame    (frame),
    .cfg_regs (cfg_regs),
    .tok      (front_tok),
    .tok_push (tok_push),
    .q_full   (q_full)
  );

  tfe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (tok_push),
    .wr_data (front_tok),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (head_tok),
    .empty   (q_empty)
  );

  tfe_back #(
    .VALID_PIXELS (VALID_PIXELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .tok      (head_tok),
    .q_empty  (q_empty),
    .pop      (q_pop),
    .result   (result)
  );
endmodule

// ===== hw/rtl/tfe_checker.sv =====
// port-level checker for thermal_frame_extremes, attached by bind
// depends on tfe_pkg and thermal_frame_extremes_defines.svh
`include "thermal_frame_extremes_defines.svh"

module tfe_checker #(
  parameter int unsigned VALID_PIXELS = 4785
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   result_valid,
  input logic                                   result_ready,
  input logic [tfe_pkg::REF_TEMP_W-1:0]         ref_temp,
  input logic [tfe_pkg::BODY_TEMP_W-1:0]        body_temp,
  input logic signed [tfe_pkg::MIN_TEMP_W-1:0]  min_temp,
  input logic [tfe_pkg::COUNT_W-1:0]            count
);
  import tfe_pkg::*;

  `TFE_ASSERT_NXT(a_result_held, clk, rst, result_valid && !result_ready, result_valid)
  `TFE_ASSERT_NXT(a_result_stable, clk, rst, result_valid && !result_ready, $stable(ref_temp) && $stable(body_temp) && $stable(min_temp) && $stable(count))
  `TFE_ASSERT_IMP(a_count_bound, clk, rst, result_valid, count <= COUNT_W'(VALID_PIXELS))
  `TFE_ASSERT_IMP(a_empty_frame, clk, rst, result_valid && (count == '0), (ref_temp == '0) && (body_temp == '0) && (min_temp == $signed(NO_MIN_TEMP)))
endmodule

bind thermal_frame_extremes tfe_checker #(
  .VALID_PIXELS (VALID_PIXELS)
) u_tfe_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .ref_temp     (result.reference_max_temp),
  .body_temp    (result.body_max_temp),
  .min_temp     (result.scene_min_temp),
  .count        (result.pixel_count)
);
